/* rtl/rtcb_pkg.sv */
// Shared types, codes and BCD helpers for the three-wire RTC bus master.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
`default_nettype none

package rtcb_pkg;

  // operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_RD_ONE   = 3'd1;
  localparam logic [2:0] OP_WR_ONE   = 3'd2;
  localparam logic [2:0] OP_WR_BURST = 3'd3;
  localparam logic [2:0] OP_RD_BURST = 3'd4;

  // bus phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_RD_ONE   = 8'h81;
  localparam logic [7:0] CMD_WR_ONE   = 8'h80;
  localparam logic [7:0] CMD_WR_BURST = 8'hBE;
  localparam logic [7:0] CMD_RD_BURST = 8'hBF;
  localparam logic [7:0] CMD_WP       = 8'h8E;
  localparam logic [7:0] HOUR_MASK    = 8'h7F;

  localparam int         TX_DEPTH   = 10;
  localparam int         RX_DEPTH   = 8;
  localparam logic [7:0] HP_RESET   = 8'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] address;
    logic [7:0] write_data;
    logic [6:0] sec_in;
    logic [6:0] min_in;
    logic [6:0] hour_in;
    logic [6:0] day_in;
    logic [6:0] month_in;
    logic [6:0] weekday_in;
    logic [6:0] year_in;
    logic       io_in;
  } item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       ready_res;
    logic [7:0] read_data;
    logic [7:0] sec_out;
    logic [7:0] min_out;
    logic [6:0] hour_out;
    logic [7:0] day_out;
    logic [7:0] month_out;
    logic [7:0] weekday_out;
    logic [7:0] year_out;
  } result_t;

  // binary to BCD, divide by ten through reciprocal 205/2048
  function automatic logic [7:0] to_bcd(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(x) * 15'(205);
    q    = prod[14:11];
    r    = x - 7'(q) * 7'(10);
    return {q, r[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'(b[3:0]) + 8'(b[7:4]) * 8'(10);
  endfunction

endpackage

`default_nettype wire

/* rtl/three_wire_rtc_bus_master.sv */
// Top level of the three-wire RTC bus master: input stage, sequencer, result stage.
// Depends on rtcb_pkg, rtcb_in_stage, rtcb_sequencer and rtcb_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Moves per transfer
// in_       in_valid / in_ready   one bus tick: op, address, data, time fields, io_in
// out_      out_valid / out_ready pin levels, idle flag, last single-read byte, decoded time
// cfg_      cfg_write_en          half_period, taken on any edge with the enable high
//
// One tick per cycle sustained while out_ready stays high; a tick passes through the
// input register, then sequencer logic into the result register, and out from there.
// The sequencer state advances only when a registered tick moves to the result
// register, so stalls on out_ready freeze the bus exactly where it stands.
// Synchronous active-low reset: sequencer idle, enable and clock low, data released.

module three_wire_rtc_bus_master (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,

  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_op,
  input  wire logic [5:0] in_address,
  input  wire logic [7:0] in_write_data,
  input  wire logic [6:0] in_sec_in,
  input  wire logic [6:0] in_min_in,
  input  wire logic [6:0] in_hour_in,
  input  wire logic [6:0] in_day_in,
  input  wire logic [6:0] in_month_in,
  input  wire logic [6:0] in_weekday_in,
  input  wire logic [6:0] in_year_in,
  input  wire logic       in_io_in,

  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_chip_enable,
  output logic            out_serial_clock,
  output logic            out_io_out,
  output logic            out_ready_res,
  output logic [7:0]      out_read_data,
  output logic [7:0]      out_sec_out,
  output logic [7:0]      out_min_out,
  output logic [6:0]      out_hour_out,
  output logic [7:0]      out_day_out,
  output logic [7:0]      out_month_out,
  output logic [7:0]      out_weekday_out,
  output logic [7:0]      out_year_out
);

  rtcb_pkg::item_t   in_item;
  rtcb_pkg::item_t   stg_item;
  rtcb_pkg::result_t seq_res;
  rtcb_pkg::result_t res;
  logic              stg_valid;
  logic              can_load;
  logic              take;

  // pack the input ports into one item
  always_comb begin
    in_item.op         = in_op;
    in_item.address    = in_address;
    in_item.write_data = in_write_data;
    in_item.sec_in     = in_sec_in;
    in_item.min_in     = in_min_in;
    in_item.hour_in    = in_hour_in;
    in_item.day_in     = in_day_in;
    in_item.month_in   = in_month_in;
    in_item.weekday_in = in_weekday_in;
    in_item.year_in    = in_year_in;
    in_item.io_in      = in_io_in;
  end

  // a registered tick runs through the sequencer when the result slot is free
  assign take = stg_valid && can_load;

  rtcb_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .take      (take),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  rtcb_sequencer u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .take           (take),
    .item           (stg_item),
    .res            (seq_res)
  );

  rtcb_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_in    (seq_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res)
  );

  // unpack the result onto the ports
  assign out_chip_enable  = res.chip_enable;
  assign out_serial_clock = res.serial_clock;
  assign out_io_out       = res.io_out;
  assign out_ready_res    = res.ready_res;
  assign out_read_data    = res.read_data;
  assign out_sec_out      = res.sec_out;
  assign out_min_out      = res.min_out;
  assign out_hour_out     = res.hour_out;
  assign out_day_out      = res.day_out;
  assign out_month_out    = res.month_out;
  assign out_weekday_out  = res.weekday_out;
  assign out_year_out     = res.year_out;

endmodule

`default_nettype wire

/* rtl/rtcb_in_stage.sv */
// Input register stage: holds one accepted tick until the sequencer takes it.
// Depends on rtcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtcb_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rtcb_pkg::item_t in_item,
  input  wire logic           take,
  output logic                stg_valid,
  output rtcb_pkg::item_t     stg_item
);

  logic            valid_r, valid_nxt;
  rtcb_pkg::item_t item_r;

  assign in_ready  = !valid_r || take;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/rtcb_sequencer.sv */
// Bus sequencer: phase, bit/byte counters, divider, frame buffers and pins.
// Advances one tick per take; depends on rtcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtcb_sequencer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_write_en,
  input  wire logic [7:0]      cfg_write_data,
  input  wire logic            take,
  input  wire rtcb_pkg::item_t item,
  output rtcb_pkg::result_t    res
);

  logic [7:0] hp_r;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] byte_r, byte_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] div_r, div_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [2:0] aop_r, aop_nxt;
  logic       ce_r, ce_nxt;
  logic       clk_r, clk_nxt;
  logic       io_r, io_nxt;
  logic [7:0] tx_r  [rtcb_pkg::TX_DEPTH];
  logic [7:0] tx_nxt[rtcb_pkg::TX_DEPTH];
  logic [7:0] rx_r  [rtcb_pkg::RX_DEPTH];
  logic [7:0] rx_nxt[rtcb_pkg::RX_DEPTH];

  logic [7:0] hp_eff;
  logic [7:0] div_inc;
  logic [7:0] addr2;
  logic [3:0] rx_k;

  function automatic logic is_read(input logic [2:0] op, input logic [3:0] bidx);
    return (op == rtcb_pkg::OP_RD_ONE && bidx == 4'd1) ||
           (op == rtcb_pkg::OP_RD_BURST && bidx != 4'd0);
  endfunction

  function automatic logic [3:0] frame_total(input logic [2:0] op);
    case (op)
      rtcb_pkg::OP_RD_ONE:   return 4'd2;
      rtcb_pkg::OP_WR_ONE:   return 4'd2;
      rtcb_pkg::OP_WR_BURST: return 4'd11;
      rtcb_pkg::OP_RD_BURST: return 4'd9;
      default:               return 4'd0;
    endcase
  endfunction

  // data bit for the position the sequencer moves to, from the new frame bytes
  function automatic logic drive_bit(input logic [2:0] op, input logic [3:0] bidx,
                                     input logic [2:0] bitx);
    logic [3:0] idx;
    logic [7:0] sel;
    idx = bidx;
    sel = 8'd0;
    if (op == rtcb_pkg::OP_WR_BURST) begin
      idx = bidx - 4'd2;
    end
    if (op == rtcb_pkg::OP_WR_BURST && bidx == 4'd0) begin
      sel = rtcb_pkg::CMD_WP;
    end else if (op == rtcb_pkg::OP_WR_BURST && bidx == 4'd1) begin
      sel = 8'd0;
    end else if (idx < 4'(rtcb_pkg::TX_DEPTH)) begin
      sel = tx_nxt[idx];
    end
    return is_read(op, bidx) ? 1'b1 : sel[bitx];
  endfunction

  assign hp_eff  = (hp_r == 8'd0) ? 8'd1 : hp_r;
  assign div_inc = div_r + 8'd1;
  assign addr2   = {item.address, 1'b0};
  assign rx_k    = byte_r - 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    div_nxt   = div_r;
    sh_nxt    = sh_r;
    aop_nxt   = aop_r;
    ce_nxt    = ce_r;
    clk_nxt   = clk_r;
    io_nxt    = io_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    unique case (phase_r)
      rtcb_pkg::PH_IDLE: begin
        if (item.op >= rtcb_pkg::OP_RD_ONE && item.op <= rtcb_pkg::OP_RD_BURST) begin
          for (int i = 0; i < rtcb_pkg::TX_DEPTH; i++) begin
            tx_nxt[i] = 8'd0;
          end
          case (item.op)
            rtcb_pkg::OP_RD_ONE: begin
              tx_nxt[0] = rtcb_pkg::CMD_RD_ONE | addr2;
            end
            rtcb_pkg::OP_WR_ONE: begin
              tx_nxt[0] = rtcb_pkg::CMD_WR_ONE | addr2;
              tx_nxt[1] = item.write_data;
            end
            rtcb_pkg::OP_WR_BURST: begin
              tx_nxt[0] = rtcb_pkg::CMD_WR_BURST;
              tx_nxt[1] = rtcb_pkg::to_bcd(item.sec_in);
              tx_nxt[2] = rtcb_pkg::to_bcd(item.min_in);
              // bit 7 clear selects 24-hour mode
              tx_nxt[3] = rtcb_pkg::to_bcd(item.hour_in) & rtcb_pkg::HOUR_MASK;
              tx_nxt[4] = rtcb_pkg::to_bcd(item.day_in);
              tx_nxt[5] = rtcb_pkg::to_bcd(item.month_in);
              tx_nxt[6] = rtcb_pkg::to_bcd(item.weekday_in);
              tx_nxt[7] = rtcb_pkg::to_bcd(item.year_in);
            end
            default: begin
              tx_nxt[0] = rtcb_pkg::CMD_RD_BURST;
            end
          endcase
          aop_nxt   = item.op;
          byte_nxt  = 4'd0;
          bit_nxt   = 3'd0;
          div_nxt   = 8'd0;
          sh_nxt    = 8'd0;
          ce_nxt    = 1'b1;
          clk_nxt   = 1'b0;
          io_nxt    = drive_bit(aop_nxt, byte_nxt, bit_nxt);
          phase_nxt = rtcb_pkg::PH_LOW;
        end
      end
      rtcb_pkg::PH_LOW: begin
        div_nxt = div_inc;
        if (div_inc >= hp_eff) begin
          if (is_read(aop_r, byte_r)) begin
            sh_nxt = {item.io_in, sh_r[7:1]};
          end
          div_nxt   = 8'd0;
          clk_nxt   = 1'b1;
          phase_nxt = rtcb_pkg::PH_HIGH;
        end
      end
      rtcb_pkg::PH_HIGH: begin
        div_nxt = div_inc;
        if (div_inc >= hp_eff) begin
          div_nxt = 8'd0;
          if (bit_r != 3'd7) begin
            bit_nxt   = bit_r + 3'd1;
            ce_nxt    = 1'b1;
            clk_nxt   = 1'b0;
            io_nxt    = drive_bit(aop_nxt, byte_nxt, bit_nxt);
            phase_nxt = rtcb_pkg::PH_LOW;
          end else begin
            bit_nxt = 3'd0;
            if (is_read(aop_r, byte_r)) begin
              if (aop_r == rtcb_pkg::OP_RD_ONE) begin
                rx_nxt[rtcb_pkg::RX_DEPTH-1] = sh_r;
              end else if (rx_k < 4'd7) begin
                rx_nxt[rx_k[2:0]] = sh_r;
              end
            end
            byte_nxt = byte_r + 4'd1;
            if (aop_r == rtcb_pkg::OP_WR_BURST && byte_nxt == 4'd2) begin
              // write-protect frame done, drop enable for the gap
              ce_nxt    = 1'b0;
              clk_nxt   = 1'b0;
              io_nxt    = 1'b1;
              phase_nxt = rtcb_pkg::PH_GAP;
            end else if (byte_nxt >= frame_total(aop_r)) begin
              ce_nxt    = 1'b0;
              clk_nxt   = 1'b0;
              io_nxt    = (aop_r != rtcb_pkg::OP_RD_BURST);
              phase_nxt = rtcb_pkg::PH_IDLE;
            end else begin
              ce_nxt    = 1'b1;
              clk_nxt   = 1'b0;
              io_nxt    = drive_bit(aop_nxt, byte_nxt, bit_nxt);
              phase_nxt = rtcb_pkg::PH_LOW;
            end
          end
        end
      end
      rtcb_pkg::PH_GAP: begin
        div_nxt = div_inc;
        if (div_inc >= hp_eff) begin
          div_nxt   = 8'd0;
          ce_nxt    = 1'b1;
          clk_nxt   = 1'b0;
          io_nxt    = drive_bit(aop_nxt, byte_nxt, bit_nxt);
          phase_nxt = rtcb_pkg::PH_LOW;
        end
      end
      default: begin
        phase_nxt = rtcb_pkg::PH_IDLE;
      end
    endcase
  end

  // result shows the levels after this tick
  always_comb begin
    res.chip_enable  = ce_nxt;
    res.serial_clock = clk_nxt;
    res.io_out       = io_nxt;
    res.ready_res    = (phase_nxt == rtcb_pkg::PH_IDLE);
    res.read_data    = rx_nxt[rtcb_pkg::RX_DEPTH-1];
    res.sec_out      = rtcb_pkg::from_bcd(rx_nxt[0]);
    res.min_out      = rtcb_pkg::from_bcd(rx_nxt[1]);
    res.hour_out     = 7'(rtcb_pkg::from_bcd(rx_nxt[2] & rtcb_pkg::HOUR_MASK));
    res.day_out      = rtcb_pkg::from_bcd(rx_nxt[3]);
    res.month_out    = rtcb_pkg::from_bcd(rx_nxt[4]);
    res.weekday_out  = rtcb_pkg::from_bcd(rx_nxt[5]);
    res.year_out     = rtcb_pkg::from_bcd(rx_nxt[6]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= rtcb_pkg::HP_RESET;
    end else if (cfg_write_en) begin
      hp_r <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rtcb_pkg::PH_IDLE;
      byte_r  <= 4'd0;
      bit_r   <= 3'd0;
      div_r   <= 8'd0;
      sh_r    <= 8'd0;
      aop_r   <= rtcb_pkg::OP_TICK;
      ce_r    <= 1'b0;
      clk_r   <= 1'b0;
      io_r    <= 1'b1;
      for (int i = 0; i < rtcb_pkg::RX_DEPTH; i++) begin
        rx_r[i] <= 8'd0;
      end
    end else if (take) begin
      phase_r <= phase_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      div_r   <= div_nxt;
      sh_r    <= sh_nxt;
      aop_r   <= aop_nxt;
      ce_r    <= ce_nxt;
      clk_r   <= clk_nxt;
      io_r    <= io_nxt;
      rx_r    <= rx_nxt;
    end
  end

  // frame bytes are written at operation start before any read
  always_ff @(posedge clk) begin
    if (take) begin
      tx_r <= tx_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rtcb_out_stage.sv */
// Result register: holds one result until the consumer takes it.
// Depends on rtcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtcb_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire rtcb_pkg::result_t res_in,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rtcb_pkg::result_t      res_out
);

  logic              valid_r, valid_nxt;
  rtcb_pkg::result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire
